// ===== design/gb3_pkg.sv =====
`timescale 1ns / 1ps

package gb3_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int CHANNELS   = 3;

	localparam int SAMPLE_W = 8;
	localparam int CFG_W    = 11;
	localparam int CFG_IDX_W = 2;
	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int ROW_W    = $clog2(MAX_HEIGHT);
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ADDR_W   = $clog2(MAX_WIDTH * CHANNELS);
	localparam int SUM_W    = SAMPLE_W + 4;

	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	// one filtered sample, marker set when a row-end word must follow it
	typedef struct packed {
		logic [SAMPLE_W-1:0] pixel;
		logic                marker;
	} gb3_result_t;

endpackage

// ===== design/gb3_front.sv =====
`timescale 1ns / 1ps

module gb3_front import gb3_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [SAMPLE_W-1:0]  sample,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 push,
	output gb3_result_t          push_data,
	input  logic                 full
);

	logic [COL_W-1:0] w_last_q;
	logic [ROW_W-1:0] h_last_q;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [CH_W-1:0]  ch_q;

	logic                valid_s1;
	logic [SAMPLE_W-1:0] s_s1;
	logic [CH_W-1:0]     ch_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic                emit_s1;
	logic                marker_s1;

	// each word holds {row r-1, row r-2} for one column and channel
	logic [2*SAMPLE_W-1:0] line_mem [MAX_WIDTH*CHANNELS];
	logic [2*SAMPLE_W-1:0] rd_q;

	logic [SAMPLE_W-1:0] win_q [CHANNELS][2][3];

	logic                accept;
	logic                adv;
	logic                last_ch;
	logic                last_col;
	logic                emit;
	logic [ADDR_W-1:0]   addr;
	logic [SAMPLE_W-1:0] top;
	logic [SAMPLE_W-1:0] mid;
	logic [SUM_W-1:0]    sum;

	function automatic logic [CFG_W-1:0] last_index(input logic [CFG_W-1:0] v,
			input logic [CFG_W-1:0] hi);
		logic [CFG_W-1:0] r;
		if (v < CFG_W'(3))
			r = CFG_W'(2);
		else if (v > hi)
			r = hi - CFG_W'(1);
		else
			r = v - CFG_W'(1);
		return r;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= COL_W'(RESET_WIDTH - 1);
			h_last_q <= ROW_W'(RESET_HEIGHT - 1);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					w_last_q <= COL_W'(last_index(cfg_data, CFG_W'(MAX_WIDTH)));
				end
				REG_IMAGE_HEIGHT: begin
					h_last_q <= ROW_W'(last_index(cfg_data, CFG_W'(MAX_HEIGHT)));
				end
				default: begin
				end
			endcase
		end
	end

	assign adv      = valid_s1 && !(emit_s1 && full);
	assign in_stall = valid_s1 && emit_s1 && full;
	assign accept   = in_valid && !in_stall;

	assign last_ch  = (ch_q >= CH_W'(CHANNELS - 1));
	assign last_col = (col_q >= w_last_q);
	assign emit     = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
	assign addr     = ADDR_W'(col_q * CHANNELS) + ADDR_W'(ch_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			ch_q  <= '0;
		end else if (accept) begin
			if (last_ch) begin
				ch_q <= '0;
				if (last_col) begin
					col_q <= '0;
					if (row_q >= h_last_q)
						row_q <= '0;
					else
						row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end else begin
				ch_q <= ch_q + CH_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s_s1      <= sample;
			ch_s1     <= ch_q;
			addr_s1   <= addr;
			emit_s1   <= emit;
			marker_s1 <= emit && last_ch && last_col;
		end
	end

	// consecutive words never share an address, so the write-back never races a read
	always_ff @(posedge clk) begin
		if (accept)
			rd_q <= line_mem[addr];
		if (adv)
			line_mem[addr_s1] <= {s_s1, rd_q[2*SAMPLE_W-1:SAMPLE_W]};
	end

	assign top = rd_q[SAMPLE_W-1:0];
	assign mid = rd_q[2*SAMPLE_W-1:SAMPLE_W];

	always_ff @(posedge clk) begin
		if (adv) begin
			win_q[ch_s1][0][0] <= win_q[ch_s1][1][0];
			win_q[ch_s1][0][1] <= win_q[ch_s1][1][1];
			win_q[ch_s1][0][2] <= win_q[ch_s1][1][2];
			win_q[ch_s1][1][0] <= top;
			win_q[ch_s1][1][1] <= mid;
			win_q[ch_s1][1][2] <= s_s1;
		end
	end

	always_comb begin
		sum = SUM_W'(win_q[ch_s1][0][0])
			+ SUM_W'({win_q[ch_s1][0][1], 1'b0})
			+ SUM_W'(win_q[ch_s1][0][2])
			+ SUM_W'({win_q[ch_s1][1][0], 1'b0})
			+ SUM_W'({win_q[ch_s1][1][1], 2'b00})
			+ SUM_W'({win_q[ch_s1][1][2], 1'b0})
			+ SUM_W'(top)
			+ SUM_W'({mid, 1'b0})
			+ SUM_W'(s_s1);
	end

	assign push             = adv && emit_s1;
	assign push_data.pixel  = sum[SUM_W-1:4];
	assign push_data.marker = marker_s1;

endmodule

// ===== design/gb3_fifo.sv =====
`timescale 1ns / 1ps

module gb3_fifo import gb3_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  gb3_result_t push_data,
	output logic        full,
	input  logic        pop,
	output logic        pop_valid,
	output gb3_result_t pop_data
);

	gb3_result_t           mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wptr_q;
	logic [FIFO_PTR_W-1:0] rptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full      = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = mem_q[rptr_q];

	assign do_push = push && !full;
	assign do_pop  = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wptr_q <= wptr_q + FIFO_PTR_W'(1);
			if (do_pop)
				rptr_q <= rptr_q + FIFO_PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + FIFO_CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - FIFO_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wptr_q] <= push_data;
	end

endmodule

// ===== design/gb3_back.sv =====
`timescale 1ns / 1ps

module gb3_back import gb3_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	input  gb3_result_t         pop_data,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [SAMPLE_W-1:0] pixel,
	output logic                row_end
);

	logic                out_valid_q;
	logic                pend_q;
	logic [SAMPLE_W-1:0] pixel_q;
	logic                row_end_q;

	logic can_load;

	assign can_load = !out_valid_q || !out_stall;
	// a pending row-end word goes out before the next queued pixel
	assign pop      = can_load && !pend_q && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (can_load) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (pop_valid) begin
				out_valid_q <= 1'b1;
				pend_q      <= pop_data.marker;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (can_load) begin
			if (pend_q) begin
				pixel_q   <= '0;
				row_end_q <= 1'b1;
			end else if (pop_valid) begin
				pixel_q   <= pop_data.pixel;
				row_end_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign pixel     = pixel_q;
	assign row_end   = row_end_q;

endmodule

// ===== design/gaussian_blur_3x3_rgb_stream_top.sv =====
`timescale 1ns / 1ps

// 3x3 gaussian blur ([1 2 1; 2 4 2; 1 2 1] / 16, truncated) over an interleaved
// R,G,B sample stream, one 8-bit sample per word, row by row. Only interior pixels
// come out, one word per channel in input order, and after each output row a
// row-end word (pixel 0, row_end 1) follows. A frame of image_height rows gives
// image_height-2 output rows; the counters then wrap. Width and height are clamped
// to 3..1024 and may be written only while the block is idle. The block takes one
// sample every cycle while in_stall is low: the line store is a single 3072 x 16
// memory read and written back once per sample; a filter result is registered
// in the queue and the output register. A row-end word needs an output slot of its
// own, absorbed by a four-entry queue between the filter and the output register.
// The line store needs no clearing after reset; a frame's first two rows fill it.

module gaussian_blur_3x3_rgb_stream_top import gb3_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [SAMPLE_W-1:0]  sample,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [SAMPLE_W-1:0]  pixel,
	output logic                 row_end,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic        push;
	gb3_result_t push_data;
	logic        full;
	logic        pop;
	logic        pop_valid;
	gb3_result_t pop_data;

	gb3_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	gb3_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_data  (pop_data)
	);

	gb3_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel     (pixel),
		.row_end   (row_end)
	);

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import gb3_pkg::*;

	localparam int MIN_SIZE       = 3;
	localparam int CFG_MAX        = (1 << CFG_W) - 1;
	localparam int RANDOM_ITEMS   = 1480;
	localparam int DRAIN_LIMIT    = 5000;
	localparam int SETTLE_CYCLES  = 12;
	localparam int CYCLE_LIMIT    = 3_000_000;
	localparam int PRINT_LIMIT    = 50;

	// indexes past the register list, writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

	typedef struct packed {
		logic [SAMPLE_W-1:0] pixel;
		logic                row_end;
	} blur_word_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [SAMPLE_W-1:0]  sample;
	logic                 out_valid;
	logic                 out_stall;
	logic [SAMPLE_W-1:0]  pixel;
	logic                 row_end;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	gaussian_blur_3x3_rgb_stream_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel     (pixel),
		.row_end   (row_end),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// blur predictor state
	logic [CFG_W-1:0]    width_reg;
	logic [CFG_W-1:0]    height_reg;
	logic [SAMPLE_W-1:0] line_mem [2][MAX_WIDTH][CHANNELS];
	logic [SAMPLE_W-1:0] win [CHANNELS][2][3];
	int                  col_cnt;
	int                  ch_cnt;
	int                  row_cnt;

	blur_word_t pending_words[$];
	blur_word_t head_word;
	int         mismatch_count = 0;
	int         cycle_count = 0;
	int         samples_sent = 0;
	int         burst_left = 0;
	int         stall_mode = 0;
	int         stall_span = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("ERROR cycle %0d: %s", cycle_count, msg);
	endtask

	function automatic int eff_width();
		if (width_reg < MIN_SIZE)
			return MIN_SIZE;
		if (width_reg > MAX_WIDTH)
			return MAX_WIDTH;
		return int'(width_reg);
	endfunction

	function automatic bit at_frame_top();
		return row_cnt == 0 && col_cnt == 0 && ch_cnt == 0;
	endfunction

	function automatic void blur_predict(input logic [SAMPLE_W-1:0] s);
		int w, h, x, c, acc;
		logic [SAMPLE_W-1:0] top, mid;
		bit last_ch, last_col;
		w = eff_width();
		h = (height_reg < MIN_SIZE) ? MIN_SIZE : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT
			: int'(height_reg);
		x = col_cnt;
		c = ch_cnt;
		top = line_mem[0][x][c];
		mid = line_mem[1][x][c];
		line_mem[0][x][c] = mid;
		line_mem[1][x][c] = s;
		acc = win[c][0][0] + 2 * win[c][0][1] + win[c][0][2]
			+ 2 * win[c][1][0] + 4 * win[c][1][1] + 2 * win[c][1][2]
			+ top + 2 * mid + s;
		win[c][0] = win[c][1];
		win[c][1][0] = top;
		win[c][1][1] = mid;
		win[c][1][2] = s;
		last_ch = ch_cnt >= CHANNELS - 1;
		last_col = col_cnt >= w - 1;
		if (row_cnt >= 2 && col_cnt >= 2) begin
			pending_words.push_back('{pixel: SAMPLE_W'(acc >> 4), row_end: 1'b0});
			if (last_ch && last_col)
				pending_words.push_back('{pixel: '0, row_end: 1'b1});
		end
		if (last_ch) begin
			ch_cnt = 0;
			if (last_col) begin
				col_cnt = 0;
				row_cnt = (row_cnt >= h - 1) ? 0 : row_cnt + 1;
			end else begin
				col_cnt++;
			end
		end else begin
			ch_cnt++;
		end
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return SAMPLE_W'($urandom_range(0, 255));
		endcase
	endfunction

	// one sample word, sent in bursts with random gaps
	task automatic push_sample(input logic [SAMPLE_W-1:0] s);
		int gap;
		cfg_valid <= 1'b0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (in_stall !== 1'b0);
		blur_predict(s);
		samples_sent++;
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_IMAGE_WIDTH:  width_reg = CFG_W'(val);
			REG_IMAGE_HEIGHT: height_reg = CFG_W'(val);
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_words.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_words.size() != 0) begin
			report_mismatch($sformatf("%0d words never arrived", pending_words.size()));
			pending_words.delete();
		end
		// rows 0 and 1 give no words but may still be in the pipeline
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic finish_frame();
		while (!at_frame_top())
			push_sample(pick_sample());
	endtask

	task automatic test_reset_values();
		// a few columns at the default size, then cut the row short and close a small frame
		repeat (5 * CHANNELS) push_sample(pick_sample());
		wait_drained();
		cfg_write(REG_IMAGE_WIDTH, MIN_SIZE);
		cfg_write(REG_IMAGE_HEIGHT, MIN_SIZE);
		finish_frame();
	endtask

	task automatic test_directed();
		wait_drained();
		cfg_write(REG_IMAGE_HEIGHT, 0);
		finish_frame();
		wait_drained();
		cfg_write(REG_IMAGE_WIDTH, 0);
		cfg_write(REG_SPARE_2, CFG_MAX);
		cfg_write(REG_SPARE_3, 0);
		// full-scale frame with a dark center pixel
		for (int i = 0; i < 3 * MIN_SIZE * CHANNELS; i++)
			push_sample((i >= 12 && i < 15) ? '0 : '1);
	endtask

	task automatic test_mid_frame_writes();
		wait_drained();
		cfg_write(REG_IMAGE_WIDTH, 8);
		cfg_write(REG_IMAGE_HEIGHT, 10);
		repeat ((2 * 8 + 6) * CHANNELS) push_sample(pick_sample());
		// column 6 is past the new last column, so this pixel ends the row
		wait_drained();
		cfg_write(REG_IMAGE_WIDTH, 4);
		repeat (CHANNELS + 3 * 4 * CHANNELS) push_sample(pick_sample());
		// row 6 is past the new last row, so the frame wraps after it
		wait_drained();
		cfg_write(REG_IMAGE_HEIGHT, MIN_SIZE);
		finish_frame();
		repeat (3 * 4 * CHANNELS) push_sample(pick_sample());
	endtask

	task automatic test_widest_frame();
		wait_drained();
		cfg_write(REG_IMAGE_WIDTH, CFG_MAX);
		cfg_write(REG_IMAGE_HEIGHT, MIN_SIZE);
		// the first row must run well past the small widths, then a shrink ends it
		repeat (40 * CHANNELS) push_sample(pick_sample());
		wait_drained();
		cfg_write(REG_IMAGE_WIDTH, MIN_SIZE);
		finish_frame();
	endtask

	task automatic test_tallest_frame();
		wait_drained();
		cfg_write(REG_IMAGE_WIDTH, MIN_SIZE);
		cfg_write(REG_IMAGE_HEIGHT, CFG_MAX);
		// rows keep coming well past the small heights, then a shrink wraps the frame
		repeat (12 * MIN_SIZE * CHANNELS) push_sample(pick_sample());
		wait_drained();
		cfg_write(REG_IMAGE_HEIGHT, MIN_SIZE);
		finish_frame();
	endtask

	task automatic test_random_frames();
		int first, new_w, mode, n;
		first = samples_sent;
		wait_drained();
		cfg_write(REG_IMAGE_HEIGHT, 8);
		while (samples_sent - first < RANDOM_ITEMS) begin
			wait_drained();
			if ($urandom_range(0, 2) != 0) begin
				// mid-frame only shrink, wider columns of the line store hold nothing yet
				if (at_frame_top())
					new_w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MIN_SIZE - 1)
						: $urandom_range(MIN_SIZE, 12);
				else
					new_w = $urandom_range(0, eff_width());
				cfg_write(REG_IMAGE_WIDTH, new_w);
				if ($urandom_range(0, 1) == 0)
					cfg_write(REG_IMAGE_HEIGHT, ($urandom_range(0, 7) == 0)
						? $urandom_range(0, MIN_SIZE - 1) : $urandom_range(MIN_SIZE, 8));
				if ($urandom_range(0, 7) == 0)
					cfg_write(($urandom_range(0, 1) == 0) ? REG_SPARE_2 : REG_SPARE_3,
						$urandom_range(0, CFG_MAX));
			end
			mode = $urandom_range(0, 3);
			if (mode == 0) begin
				finish_frame();
			end else begin
				n = (mode == 3) ? $urandom_range(1, 40)
					: $urandom_range(1, 4) * eff_width() * CHANNELS;
				repeat (n) push_sample(pick_sample());
			end
		end
	endtask

	// receiver stall pattern: runs of free flow, light, heavy and periodic stalls
	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_span <= $urandom_range(16, 200);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= stall_span[2];
		endcase
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word pixel %0d row_end %0b", pixel,
					row_end));
			end else begin
				head_word = pending_words.pop_front();
				if (pixel !== head_word.pixel)
					report_mismatch($sformatf("pixel %0d, expected %0d", pixel,
						head_word.pixel));
				if (row_end !== head_word.row_end)
					report_mismatch($sformatf("row_end %0b, expected %0b", row_end,
						head_word.row_end));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		width_reg = CFG_W'(RESET_WIDTH);
		height_reg = CFG_W'(RESET_HEIGHT);
		col_cnt = 0;
		ch_cnt = 0;
		row_cnt = 0;
		foreach (win[c, k, r])
			win[c][k][r] = '0;
		foreach (line_mem[s, x, c])
			line_mem[s][x][c] = '0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		sample <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_directed();
		test_mid_frame_writes();
		test_widest_frame();
		test_tallest_frame();
		test_random_frames();
		wait_drained();
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
